// ===== sv/cfcb_pkg.sv =====
// Package for the four-channel telemetry framer.
// Holds frame constants and the Modbus CRC-16 byte update; no dependencies.
package cfcb_pkg;

    localparam int unsigned Channels   = 4;
    localparam int unsigned SampleW    = 16;
    localparam int unsigned DataBytes  = 8;
    localparam int unsigned FrameBytes = 10;

    typedef logic [3:0] byte_idx_t;

    localparam byte_idx_t IdxCrcLo = 4'd8;
    localparam byte_idx_t IdxCrcHi = 4'd9;

    localparam logic [15:0] CrcInit     = 16'hFFFF;
    localparam logic [15:0] CrcPoly     = 16'hA001;
    localparam logic [7:0]  ByteNewline = 8'h0A;
    localparam logic [7:0]  ByteReturn  = 8'h0D;

    // Fold one byte into the CRC, eight reflected shift steps
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (c[0])
            begin
                c = (c >> 1) ^ CrcPoly;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== sv/channel_frame_crc16_builder.sv =====
// Four-channel telemetry framer: top level.
// Depends on cfcb_pkg (constants, CRC byte update).
//
// Usage
//   Pulse start with the four samples on channel_0..channel_3; the item is
//   taken at a rising edge where start is high and busy is low.
//   The block sends a 10-byte frame on out_byte, one byte per cycle, each
//   marked by byte_valid for a single cycle: the four samples low byte first,
//   then the Modbus CRC-16 (poly 0xA001 reflected, init 0xFFFF) low then high.
//   last_byte flags the tenth byte.
//   The CRC is worked out one byte per cycle as the data bytes go out, so
//   the rate is set by the byte output.
//   A one-item holding buffer sits ahead of the frame shifter; busy is high
//   only while that buffer is full, so the next item may be given while the
//   current frame is still going out and frames follow with no gap.
//   When idle, an accepted item passes the holding buffer, the frame shifter and the result register in turn.
//   cfg_we/cfg_wdata write newline_to_return (reset 1): when set, every sent
//   byte equal to 0x0A, data or CRC, goes out as 0x0D. The CRC always covers
//   the unaltered data bytes. Write it only while no frame is pending.
//   Reset clears the buffer, the frame shifter and the strobe, and sets
//   newline_to_return. The receiver cannot stall: bytes are taken as sent.
module channel_frame_crc16_builder (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  channel_0,
    input  logic signed [15:0]  channel_1,
    input  logic signed [15:0]  channel_2,
    input  logic signed [15:0]  channel_3,
    input  logic                cfg_we,
    input  logic                cfg_wdata,
    output logic                byte_valid,
    output logic [7:0]          out_byte,
    output logic                last_byte
);

    localparam int unsigned FrameW = cfcb_pkg::Channels * cfcb_pkg::SampleW;

    // holding buffer
    logic [FrameW-1:0]    pend_reg,  pend_next;
    logic                 pend_full_reg, pend_full_next;
    // frame shifter
    logic [FrameW-1:0]    data_reg,  data_next;
    cfcb_pkg::byte_idx_t  idx_reg,   idx_next;
    logic                 active_reg, active_next;
    logic [15:0]          crc_reg,   crc_next;
    // configuration
    logic                 nl_reg,    nl_next;
    // result register
    logic                 valid_reg, valid_next;
    logic [7:0]           byte_reg,  byte_next;
    logic                 last_reg,  last_next;

    logic                 accept;
    logic                 transfer;
    logic                 frame_end;
    logic [7:0]           raw_byte;

    assign busy      = pend_full_reg;
    assign accept    = start && !pend_full_reg;
    assign frame_end = active_reg && (idx_reg == cfcb_pkg::IdxCrcHi);
    // Move the buffered item into the shifter when it is free or finishing
    assign transfer  = pend_full_reg && (!active_reg || frame_end);

    always_comb
    begin
        pend_next      = pend_reg;
        pend_full_next = pend_full_reg;
        if (accept)
        begin
            pend_next      = {channel_3, channel_2, channel_1, channel_0};
            pend_full_next = 1'b1;
        end
        else if (transfer)
        begin
            pend_full_next = 1'b0;
        end
    end

    // Pick the byte for this cycle: data, then CRC low, then CRC high
    always_comb
    begin
        case (idx_reg)
            cfcb_pkg::IdxCrcLo: raw_byte = crc_reg[7:0];
            cfcb_pkg::IdxCrcHi: raw_byte = crc_reg[15:8];
            default:            raw_byte = data_reg[7:0];
        endcase
    end

    always_comb
    begin
        data_next   = data_reg;
        idx_next    = idx_reg;
        active_next = active_reg;
        crc_next    = crc_reg;
        if (transfer)
        begin
            data_next   = pend_reg;
            idx_next    = '0;
            active_next = 1'b1;
            crc_next    = cfcb_pkg::CrcInit;
        end
        else if (active_reg)
        begin
            idx_next = idx_reg + 4'd1;
            if (frame_end)
            begin
                active_next = 1'b0;
            end
            if (idx_reg < cfcb_pkg::IdxCrcLo)
            begin
                data_next = data_reg >> 8;
                crc_next  = cfcb_pkg::crc_byte(crc_reg, data_reg[7:0]);
            end
        end
    end

    // Result register, with the newline substitution applied after the CRC
    always_comb
    begin
        valid_next = active_reg;
        last_next  = frame_end;
        byte_next  = raw_byte;
        if (nl_reg && (raw_byte == cfcb_pkg::ByteNewline))
        begin
            byte_next = cfcb_pkg::ByteReturn;
        end
    end

    assign nl_next = cfg_we ? cfg_wdata : nl_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_full_reg <= 1'b0;
            active_reg    <= 1'b0;
            idx_reg       <= '0;
            crc_reg       <= cfcb_pkg::CrcInit;
            nl_reg        <= 1'b1;
            valid_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            pend_full_reg <= pend_full_next;
            active_reg    <= active_next;
            idx_reg       <= idx_next;
            crc_reg       <= crc_next;
            nl_reg        <= nl_next;
            valid_reg     <= valid_next;
            last_reg      <= last_next;
        end
    end

    // Payload registers hold no reset
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        data_reg <= data_next;
        byte_reg <= byte_next;
    end

    assign byte_valid = valid_reg;
    assign out_byte   = byte_reg;
    assign last_byte  = last_reg;

`ifndef NO_ASSERTIONS
    a_last_has_strobe : assert property (@(posedge clk) disable iff (!rst_n)
        last_byte |-> byte_valid)
        else $error("last_byte without byte_valid");

    a_active_emits : assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |=> byte_valid)
        else $error("active frame cycle gave no byte");

    a_idx_range : assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (idx_reg <= cfcb_pkg::IdxCrcHi))
        else $error("byte index past end of frame");

    a_pend_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (pend_full_reg && !transfer) |=> (pend_full_reg && $stable(pend_reg)))
        else $error("buffered item lost before transfer");
`endif

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for the four-channel telemetry framer (Modbus CRC-16).
// Drives sample sets and register writes from a queue, predicts every frame byte.
// Depends on cfcb_pkg and channel_frame_crc16_builder.
`timescale 1ns / 100ps

module testbench;

    localparam int StallLimit   = 1000; // cycles with no handshake before giving up
    localparam int SettleCycles = 3;    // quiet cycles before a register write
    localparam int DrainCycles  = 30;   // extra cycles to catch stray bytes at the end
    localparam int TailItems    = 80;   // last stretch of the run has no idling

    typedef enum logic {JobFrame, JobCfgWrite} job_kind_t;

    typedef struct packed {
        job_kind_t   kind;
        logic        cfg_val;
        logic [63:0] samples;   // {channel_3, channel_2, channel_1, channel_0}
    } job_t;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } frame_byte_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] channel_0 = '0;
    logic signed [15:0] channel_1 = '0;
    logic signed [15:0] channel_2 = '0;
    logic signed [15:0] channel_3 = '0;
    logic               cfg_we = 1'b0;
    logic               cfg_wdata = 1'b0;
    logic               byte_valid;
    logic [7:0]         out_byte;
    logic               last_byte;

    job_t        pending_jobs[$];
    frame_byte_t frame_bytes_due[$];

    // Predictor's copy of the newline_to_return register
    logic nl_to_cr = 1'b1;

    int mismatches = 0;
    int hold_off = 0;
    int quiet_count = 0;
    int stall_cycles = 0;

    channel_frame_crc16_builder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .channel_0  (channel_0),
        .channel_1  (channel_1),
        .channel_2  (channel_2),
        .channel_3  (channel_3),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .byte_valid (byte_valid),
        .out_byte   (out_byte),
        .last_byte  (last_byte)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hold reset at the start, then release it for good
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
    end

    // Modbus CRC-16 over the eight data bytes, channel_0 low byte first.
    // Reflected form: shift right, fold in the polynomial when bit 0 falls out.
    function automatic logic [15:0] modbus_crc(input logic [63:0] data);
        logic [15:0] acc;
        acc = cfcb_pkg::CrcInit;
        for (int n = 0; n < cfcb_pkg::DataBytes; n++)
        begin
            acc = acc ^ {8'h00, data[8*n +: 8]};
            for (int b = 0; b < 8; b++)
            begin
                acc = acc[0] ? ((acc >> 1) ^ cfcb_pkg::CrcPoly) : (acc >> 1);
            end
        end
        return acc;
    endfunction

    // Work out the ten bytes an accepted sample set must produce and queue them.
    // The CRC covers the raw data; the newline swap applies only on the way out.
    task automatic queue_frame(input logic [63:0] samples);
        logic [79:0] frame;
        frame_byte_t fb;
        frame = {modbus_crc(samples), samples};
        for (int k = 0; k < cfcb_pkg::FrameBytes; k++)
        begin
            fb.value = frame[8*k +: 8];
            if (nl_to_cr && fb.value == cfcb_pkg::ByteNewline)
            begin
                fb.value = cfcb_pkg::ByteReturn;
            end
            fb.last = (k == cfcb_pkg::FrameBytes - 1);
            frame_bytes_due.push_back(fb);
        end
    endtask

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic add_frame(input logic [63:0] samples);
        job_t j;
        j.kind = JobFrame;
        j.cfg_val = 1'b0;
        j.samples = samples;
        pending_jobs.push_back(j);
    endtask

    task automatic add_cfg(input logic value);
        job_t j;
        j.kind = JobCfgWrite;
        j.cfg_val = value;
        j.samples = '0;
        pending_jobs.push_back(j);
    endtask

    // Random sample set, biased per byte towards newline, return and the
    // sign/limit patterns; a quarter of the sets are plain random.
    function automatic logic [63:0] random_samples();
        logic [63:0] s;
        s = {$urandom, $urandom};
        if ($urandom_range(0, 3) != 0)
        begin
            for (int n = 0; n < cfcb_pkg::DataBytes; n++)
            begin
                case ($urandom_range(0, 15))
                    0, 1:    s[8*n +: 8] = cfcb_pkg::ByteNewline;
                    2:       s[8*n +: 8] = cfcb_pkg::ByteReturn;
                    3:       s[8*n +: 8] = 8'h00;
                    4:       s[8*n +: 8] = 8'hFF;
                    5:       s[8*n +: 8] = 8'h80;
                    6:       s[8*n +: 8] = 8'h7F;
                    default: s[8*n +: 8] = 8'($urandom);
                endcase
            end
        end
        return s;
    endfunction

    // Fill the job queue: directed frames, register phases, random frames
    initial
    begin
        logic [63:0] crc_lo_nl;
        logic [63:0] crc_hi_nl;
        logic [63:0] s;
        logic [15:0] c;

        // Search for sample sets whose CRC carries a newline in either byte
        crc_lo_nl = '0;
        crc_hi_nl = '0;
        for (int tries = 0; tries < 100000; tries++)
        begin
            s = {$urandom, $urandom};
            c = modbus_crc(s);
            if (c[7:0] == cfcb_pkg::ByteNewline)
            begin
                crc_lo_nl = s;
            end
            if (c[15:8] == cfcb_pkg::ByteNewline)
            begin
                crc_hi_nl = s;
            end
        end

        // Directed set with the register at its reset value
        add_frame(64'h0000_0000_0000_0000);
        add_frame(64'hFFFF_FFFF_FFFF_FFFF);
        add_frame(64'h7FFF_7FFF_7FFF_7FFF);
        add_frame(64'h8000_8000_8000_8000);
        add_frame(64'hFFFF_0001_7FFF_8000);
        add_frame(64'h5555_AAAA_5555_AAAA);
        add_frame(64'h0A0A_0A0A_0A0A_0A0A);
        add_frame(64'h0A00_000A_0D0A_0A0D);
        add_frame(64'h0D0D_0D0D_0D0D_0D0D);
        add_frame(crc_lo_nl);
        add_frame(crc_hi_nl);

        // Same newline cases with the swap switched off
        add_cfg(1'b0);
        add_frame(64'h0A0A_0A0A_0A0A_0A0A);
        add_frame(64'h0A00_000A_0D0A_0A0D);
        add_frame(crc_lo_nl);
        add_frame(crc_hi_nl);
        add_frame(64'h0000_0000_0000_0000);
        add_frame(64'hFFFF_FFFF_FFFF_FFFF);
        add_frame(64'h8000_7FFF_8000_7FFF);

        // Random phases, alternating the register each time
        add_cfg(1'b1);
        repeat (135) add_frame(random_samples());
        add_cfg(1'b0);
        repeat (135) add_frame(random_samples());
        add_cfg(1'b1);
        repeat (140) add_frame(random_samples());

        wait (rst_n);
        while (pending_jobs.size() != 0 || frame_bytes_due.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DrainCycles) @(posedge clk);

        if (mismatches == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Driver: present the head job, drop it once the block has taken it.
    // Each driven signal gets at most one nonblocking assignment per edge.
    always @(posedge clk or negedge rst_n)
    begin
        job_t head;
        job_t taken;
        logic next_start;
        logic next_we;

        if (!rst_n)
        begin
            start     <= 1'b0;
            cfg_we    <= 1'b0;
            cfg_wdata <= 1'b0;
            channel_0 <= '0;
            channel_1 <= '0;
            channel_2 <= '0;
            channel_3 <= '0;
            nl_to_cr = 1'b1;
            hold_off = 0;
            quiet_count = 0;
        end
        else
        begin
            next_start = 1'b0;
            next_we = 1'b0;

            // A write lands at the edge where the enable is seen high
            if (cfg_we)
            begin
                nl_to_cr = cfg_wdata;
            end

            // Item accepted: predict its frame and maybe start an idle burst
            if (start && !busy)
            begin
                taken = pending_jobs.pop_front();
                queue_frame(taken.samples);
                if (pending_jobs.size() > TailItems && $urandom_range(0, 3) == 0)
                begin
                    hold_off = $urandom_range(1, 19);
                end
            end

            // Count quiet cycles so register writes only land on an idle block
            if (frame_bytes_due.size() == 0 && !start && !cfg_we)
            begin
                quiet_count++;
            end
            else
            begin
                quiet_count = 0;
            end

            if (hold_off > 0)
            begin
                // Idle: scramble the sample lines, which must be ignored
                hold_off--;
                {channel_3, channel_2, channel_1, channel_0} <= {$urandom, $urandom};
            end
            else if (pending_jobs.size() != 0)
            begin
                head = pending_jobs[0];
                if (head.kind == JobFrame)
                begin
                    next_start = 1'b1;
                    {channel_3, channel_2, channel_1, channel_0} <= head.samples;
                end
                else if (quiet_count >= SettleCycles)
                begin
                    next_we = 1'b1;
                    cfg_wdata <= head.cfg_val;
                    void'(pending_jobs.pop_front());
                end
            end

            start  <= next_start;
            cfg_we <= next_we;
        end
    end

    // Monitor: every strobed byte must match the oldest predicted one
    always @(posedge clk)
    begin
        frame_byte_t want;
        if (rst_n && byte_valid)
        begin
            if (frame_bytes_due.size() == 0)
            begin
                report_mismatch($sformatf("byte %02h with no frame pending", out_byte));
            end
            else
            begin
                want = frame_bytes_due.pop_front();
                if (out_byte !== want.value)
                begin
                    report_mismatch($sformatf("out_byte %02h, want %02h",
                                              out_byte, want.value));
                end
                if (last_byte !== want.last)
                begin
                    report_mismatch($sformatf("last_byte %b, want %b",
                                              last_byte, want.last));
                end
            end
        end
    end

    // Watchdog: abandon the run when no handshake of any kind happens for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((start && !busy) || byte_valid || cfg_we)
            begin
                stall_cycles = 0;
            end
            else
            begin
                stall_cycles++;
                if (stall_cycles >= StallLimit)
                begin
                    $display("CHECK FAILED");
                    $finish;
                end
            end
        end
    end

endmodule
